### rtl/multi_channel_pulse_generator_macros.svh
// assertion macros shared by the pulse generator rtl
`ifndef MULTI_CHANNEL_PULSE_GENERATOR_MACROS_SVH
`define MULTI_CHANNEL_PULSE_GENERATOR_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define MCPG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCPG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mcpg_pkg.sv
// shared types and constants of the pulse generator
`default_nettype none
package mcpg_pkg;

	localparam int CHANNELS      = 8;
	localparam int CH_W          = 3;
	localparam int W_W           = 16;
	localparam int MASK_W        = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [W_W-1:0] MIN_WIDTH     = 16'd1000;
	localparam logic [W_W-1:0] DEFAULT_WIDTH = 16'd1500;
	localparam logic [W_W-1:0] MIN_PERIOD    = 16'd2;

	localparam logic [W_W-1:0]    RST_PERIOD = 16'd2500;
	localparam logic [W_W-1:0]    RST_COMMIT = 16'd100;
	localparam logic [MASK_W-1:0] RST_MASK   = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD = 2'd0,
		CFG_COMMIT = 2'd1,
		CFG_MASK   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_SET  = 1'b1
	} kind_t;

	typedef struct packed {
		logic            hold;
		logic [W_W-1:0]  width;
		logic [CH_W-1:0] channel;
		kind_t           kind;
	} item_t;

	typedef struct packed {
		logic [W_W-1:0]    width_readback;
		logic              period_start;
		logic [MASK_W-1:0] pin_levels;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage
`default_nettype wire

### rtl/mcpg_in_stage.sv
// input register stage of the pulse generator
`default_nettype none
module mcpg_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mcpg_pkg::item_t in_item,
	input  wire logic           take,
	output logic                item_valid_s1,
	output mcpg_pkg::item_t     item_s1
);

	// refill in the same cycle the held request moves on
	assign in_ready = !item_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

### rtl/mcpg_engine.sv
// period counter, width buffers and pin levels of the pulse generator
`default_nettype none
`include "multi_channel_pulse_generator_macros.svh"
module mcpg_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mcpg_pkg::cfg_wr_t cfg,
	input  wire logic             fire,
	input  wire mcpg_pkg::item_t  item,
	output mcpg_pkg::result_t     result
);

	logic [mcpg_pkg::W_W-1:0]    period_q, commit_q, tick_q;
	logic [mcpg_pkg::MASK_W-1:0] mask_q, level_q;
	logic                        pending_q;
	logic [mcpg_pkg::W_W-1:0]    staged_q [mcpg_pkg::CHANNELS];
	logic [mcpg_pkg::W_W-1:0]    active_q [mcpg_pkg::CHANNELS];

	logic [mcpg_pkg::W_W-1:0]    period_d, commit_d, tick_d;
	logic [mcpg_pkg::MASK_W-1:0] mask_d, level_d;
	logic                        pending_d;
	logic [mcpg_pkg::W_W-1:0]    staged_d [mcpg_pkg::CHANNELS];
	logic [mcpg_pkg::W_W-1:0]    active_d [mcpg_pkg::CHANNELS];

	logic [mcpg_pkg::W_W-1:0]    per_eff, hi, req_clip, req_w;
	logic [mcpg_pkg::W_W:0]      tick_inc;
	logic                        is_start, is_commit;
	logic [mcpg_pkg::MASK_W-1:0] new_mask, added;

	// effective period and clamp bounds
	assign per_eff  = (period_q < mcpg_pkg::MIN_PERIOD) ? mcpg_pkg::MIN_PERIOD : period_q;
	assign hi       = per_eff - 16'd1;
	assign req_clip = (item.width > hi) ? hi : item.width;
	assign req_w    = (req_clip < mcpg_pkg::MIN_WIDTH) ? mcpg_pkg::MIN_WIDTH : req_clip;
	assign tick_inc = {1'b0, tick_q} + 17'd1;
	assign is_start  = (tick_q == '0);
	assign is_commit = (tick_q == commit_q) && pending_q;
	assign new_mask  = cfg.data[mcpg_pkg::MASK_W-1:0];
	assign added     = new_mask & ~mask_q;

	always_comb begin
		period_d  = period_q;
		commit_d  = commit_q;
		mask_d    = mask_q;
		tick_d    = tick_q;
		level_d   = level_q;
		pending_d = pending_q;
		staged_d  = staged_q;
		active_d  = active_q;
		result    = '0;
		if (cfg.we) begin
			case (cfg.index)
				mcpg_pkg::CFG_PERIOD: period_d = cfg.data;
				mcpg_pkg::CFG_COMMIT: commit_d = cfg.data;
				mcpg_pkg::CFG_MASK: begin
					for (int ch = 0; ch < mcpg_pkg::CHANNELS; ch++) begin
						if (added[ch]) begin
							staged_d[ch] = mcpg_pkg::DEFAULT_WIDTH;
						end
					end
					if (new_mask != mask_q) begin
						pending_d = 1'b1;
					end
					mask_d  = new_mask;
					level_d = level_q & new_mask;
				end
				default: ;
			endcase
		end else if (fire) begin
			if (item.kind == mcpg_pkg::KIND_TICK) begin
				if (is_start) begin
					level_d = mask_q;
				end
				if (is_commit) begin
					active_d  = staged_q;
					pending_d = 1'b0;
				end
				for (int ch = 0; ch < mcpg_pkg::CHANNELS; ch++) begin
					if (active_d[ch] == tick_q) begin
						level_d[ch] = 1'b0;
					end
				end
				tick_d = (tick_inc >= {1'b0, per_eff}) ? '0 : tick_inc[mcpg_pkg::W_W-1:0];
				result.period_start = is_start;
			end else begin
				if (mask_q[item.channel] && (staged_q[item.channel] != req_w)) begin
					staged_d[item.channel] = req_w;
					if (!item.hold) begin
						pending_d = 1'b1;
					end
				end
				result.width_readback = staged_d[item.channel];
			end
			result.pin_levels = level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= mcpg_pkg::RST_PERIOD;
			commit_q  <= mcpg_pkg::RST_COMMIT;
			mask_q    <= mcpg_pkg::RST_MASK;
			tick_q    <= '0;
			level_q   <= '0;
			pending_q <= 1'b0;
			for (int ch = 0; ch < mcpg_pkg::CHANNELS; ch++) begin
				staged_q[ch] <= mcpg_pkg::DEFAULT_WIDTH;
				active_q[ch] <= mcpg_pkg::DEFAULT_WIDTH;
			end
		end else begin
			period_q  <= period_d;
			commit_q  <= commit_d;
			mask_q    <= mask_d;
			tick_q    <= tick_d;
			level_q   <= level_d;
			pending_q <= pending_d;
			staged_q  <= staged_d;
			active_q  <= active_d;
		end
	end

	`MCPG_ASSERT_IMP(a_level_in_mask, 1'b1, (level_q & ~mask_q) == '0, "pin high on detached channel")
	`MCPG_ASSERT_NXT(a_commit_clears, fire && !cfg.we && item.kind == mcpg_pkg::KIND_TICK && is_commit, !pending_q, "commit left pending set")
	`MCPG_ASSERT_NXT(a_count_step, fire && !cfg.we && item.kind == mcpg_pkg::KIND_TICK && is_start, tick_q == 16'd1, "count did not leave zero")

endmodule
`default_nettype wire

### rtl/multi_channel_pulse_generator.sv
// top level of the multi-channel pulse generator
// usage:
//  - s_* channel takes one request per handshake: tuser selects a one microsecond tick
//    or a width update for one channel; tdata carries channel, width and hold
//  - m_* channel returns exactly one result per request, in order: pin levels after
//    the request, a period start flag and the clamped staged width read back
//  - cfg_* channel writes period_ticks (0), commit_point (1) and channel_mask (2);
//    writes are taken every cycle and are meant for when no request is in flight
//  - registers: a request is held in the input register, then its result in the
//    result register, which drives m_*
//  - throughput: one request per cycle unless m_tready stalls the result register,
//    set by the combinational counter, width buffer and pin level update in between
//  - reset: tick count zero, all widths at the default, no commit pending,
//    all pins low, registers at their reset values, both channels empty
//  - stall: while m_tready is low the result register holds; one more request
//    waits in the input register, after which s_tready drops
`default_nettype none
`include "multi_channel_pulse_generator_macros.svh"
module multi_channel_pulse_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // channel[2:0], width[18:3], hold[19], zero pad
	input  wire logic [0:0]  s_tuser,   // kind[0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // pin_levels[7:0], period_start[8],
	                                    // width_readback[24:9], zero pad
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	mcpg_pkg::item_t   in_item, item_s1;
	mcpg_pkg::result_t result, result_q;
	mcpg_pkg::cfg_wr_t cfg;
	logic              item_valid_s1, fire, out_valid_q;

	// unpack the request
	always_comb begin
		in_item.kind    = mcpg_pkg::kind_t'(s_tuser[0]);
		in_item.channel = s_tdata[2:0];
		in_item.width   = s_tdata[18:3];
		in_item.hold    = s_tdata[19];
	end

	// register writes never stall
	assign cfg_ready = 1'b1;
	assign cfg.we    = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// a held request is taken whenever the result register can take it; the engine skips it during a register write
	assign fire = item_valid_s1 && (!out_valid_q || m_tready);

	mcpg_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_item      (in_item),
		.take         (fire),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1)
	);

	mcpg_engine u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.fire  (fire),
		.item  (item_s1),
		.result(result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, result_q.width_readback, result_q.period_start,
		result_q.pin_levels};

	`MCPG_ASSERT_IMP(a_stall_full, !s_tready, item_valid_s1 && out_valid_q && !m_tready, "input stalled with room")
	`MCPG_ASSERT_NXT(a_fire_fills, fire, out_valid_q, "processed request lost")

endmodule
`default_nettype wire
